// ===== sv/wws_pkg.sv =====
// shared widths, register indexes and the divider step for the wiener shrink block
package wws_pkg;

  localparam int unsigned COEF_W     = 16;
  localparam int unsigned NOISE_W    = 16;
  localparam int unsigned LEVEL_W    = 3;
  localparam int unsigned NUM_LEVELS = 7;
  localparam int unsigned SQ_W       = 32;
  localparam int unsigned NUM_W      = 48;
  localparam int unsigned DEN_W      = 33;
  localparam int unsigned QUO_W      = 16;
  localparam int unsigned BITS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES = QUO_W / BITS_PER_STAGE;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned DEF_ROW_BITS    = 6;
  localparam int unsigned DEF_COLUMN_BITS = 12;

  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_FIRST = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_LAST  = 4'd7;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic             bit_set;
  } div_step_t;

  // one restoring division step against den shifted left by k
  function automatic div_step_t div_step(input logic [NUM_W-1:0] rem,
                                         input logic [DEN_W-1:0] den,
                                         input int unsigned k);
    logic [NUM_W:0] shifted;
    div_step_t      res;
    shifted = (NUM_W+1)'(den) << k;
    if ({1'b0, rem} >= shifted) begin
      res.rem     = rem - shifted[NUM_W-1:0];
      res.bit_set = 1'b1;
    end else begin
      res.rem     = rem;
      res.bit_set = 1'b0;
    end
    return res;
  endfunction

endpackage

// ===== sv/wavelet_wiener_shrink.sv =====
// top level of the wavelet-domain wiener shrink pipeline
// The block takes one request per cycle (coefficient, row, column) when not stalled and returns one
// result per request, in order, through these stages: an input register stage that finds the
// detail level and its noise, a squaring stage, a cube and denominator stage, eight divider
// stages that each settle two quotient bits of |x|^3 / (x^2 + n^2), and the output register.
// The sixteen-bit restoring divider sets the depth. All stages advance together whenever the
// output register is empty or being taken, so a full stream runs at one result per clock.
// Configuration writes (index 0 level count, 1..7 noise per level) are always ready and must
// only come while the pipeline is empty; indexes above 7 are ignored.
module wavelet_wiener_shrink #(
  parameter int unsigned ROW_BITS    = wws_pkg::DEF_ROW_BITS,
  parameter int unsigned COLUMN_BITS = wws_pkg::DEF_COLUMN_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [wws_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [wws_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [wws_pkg::COEF_W-1:0]  coefficient_i,
  input  logic [ROW_BITS-1:0]                row_index_i,
  input  logic [COLUMN_BITS-1:0]             column_index_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [wws_pkg::COEF_W-1:0]  shrunk_value_o,
  output logic [wws_pkg::LEVEL_W-1:0]        band_level_o
);

  localparam int unsigned CW  = wws_pkg::COEF_W;
  localparam int unsigned LW  = wws_pkg::LEVEL_W;
  localparam int unsigned NS  = wws_pkg::DIV_STAGES;
  localparam int unsigned BS  = wws_pkg::BITS_PER_STAGE;
  localparam int unsigned NIW = $clog2(wws_pkg::NUM_LEVELS);

  // configuration registers
  logic [LW-1:0]                level_count_q;
  logic [wws_pkg::NOISE_W-1:0]  noise_q [wws_pkg::NUM_LEVELS];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_count_q <= '0;
      for (int i = 0; i < int'(wws_pkg::NUM_LEVELS); i++) noise_q[i] <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == wws_pkg::REG_LEVEL_COUNT) begin
        level_count_q <= cfg_data_i[LW-1:0];
      end else if (cfg_index_i >= wws_pkg::REG_NOISE_FIRST &&
                   cfg_index_i <= wws_pkg::REG_NOISE_LAST) begin
        noise_q[NIW'(cfg_index_i - wws_pkg::REG_NOISE_FIRST)] <= cfg_data_i;
      end
    end
  end

  // whole pipeline moves when the output slot is free or being taken
  logic out_valid_q;
  logic adv;
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // stage 1 front: band detection, lowest level wins (bands are disjoint anyway)
  logic [LW-1:0]               lvl_d;
  logic [wws_pkg::NOISE_W-1:0] noise_d;
  logic [CW-1:0]               raw_in;
  logic [CW-1:0]               mag_d;

  assign raw_in = coefficient_i;
  assign mag_d  = raw_in[CW-1] ? (CW'(0) - raw_in) : raw_in;

  always_comb begin
    logic [31:0] row_w, col_w, rb, cb;
    lvl_d   = '0;
    noise_d = '0;
    row_w   = 32'(row_index_i);
    col_w   = 32'(column_index_i);
    for (int l = int'(wws_pkg::NUM_LEVELS); l >= 1; l--) begin
      rb = (32'd1 << ROW_BITS) >> l;
      cb = (32'd1 << COLUMN_BITS) >> l;
      if (32'(l) <= 32'(level_count_q) && row_w < (rb << 1) && col_w < (cb << 1) &&
          (row_w >= rb || col_w >= cb)) begin
        lvl_d   = LW'(l);
        noise_d = noise_q[NIW'(l-1)];
      end
    end
  end

  // stage 1 registers
  logic                         v1_q, neg1_q;
  logic [CW-1:0]                raw1_q, mag1_q;
  logic [LW-1:0]                lvl1_q;
  logic [wws_pkg::NOISE_W-1:0]  noise1_q;
  // stage 2: squares
  logic                         v2_q, neg2_q;
  logic [CW-1:0]                raw2_q, mag2_q;
  logic [LW-1:0]                lvl2_q;
  logic [wws_pkg::SQ_W-1:0]     sq2_q, nn2_q;
  // stage 3: cube and denominator
  logic                         v3_q, neg3_q;
  logic [CW-1:0]                raw3_q;
  logic [LW-1:0]                lvl3_q;
  logic [wws_pkg::NUM_W-1:0]    num3_q;
  logic [wws_pkg::DEN_W-1:0]    den3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      neg1_q   <= raw_in[CW-1];
      raw1_q   <= raw_in;
      mag1_q   <= mag_d;
      lvl1_q   <= lvl_d;
      noise1_q <= noise_d;

      neg2_q <= neg1_q;
      raw2_q <= raw1_q;
      mag2_q <= mag1_q;
      lvl2_q <= lvl1_q;
      sq2_q  <= wws_pkg::SQ_W'(mag1_q) * wws_pkg::SQ_W'(mag1_q);
      nn2_q  <= wws_pkg::SQ_W'(noise1_q) * wws_pkg::SQ_W'(noise1_q);

      neg3_q <= neg2_q;
      raw3_q <= raw2_q;
      lvl3_q <= lvl2_q;
      num3_q <= wws_pkg::NUM_W'(sq2_q) * wws_pkg::NUM_W'(mag2_q);
      den3_q <= wws_pkg::DEN_W'(sq2_q) + wws_pkg::DEN_W'(nn2_q);
    end
  end

  // divider stages, two quotient bits each, msb first
  logic                          dv_q   [NS];
  logic                          dneg_q [NS];
  logic [CW-1:0]                 draw_q [NS];
  logic [LW-1:0]                 dlvl_q [NS];
  logic [wws_pkg::NUM_W-1:0]     drem_q [NS];
  logic [wws_pkg::DEN_W-1:0]     dden_q [NS];
  logic [wws_pkg::QUO_W-1:0]     dquo_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_div
    logic                      v_in, neg_in;
    logic [CW-1:0]             raw_in_s;
    logic [LW-1:0]             lvl_in;
    logic [wws_pkg::NUM_W-1:0] rem_in;
    logic [wws_pkg::DEN_W-1:0] den_in;
    logic [wws_pkg::QUO_W-1:0] quo_in;
    wws_pkg::div_step_t        st_a, st_b;

    if (s == 0) begin : g_first
      assign v_in     = v3_q;
      assign neg_in   = neg3_q;
      assign raw_in_s = raw3_q;
      assign lvl_in   = lvl3_q;
      assign rem_in   = num3_q;
      assign den_in   = den3_q;
      assign quo_in   = '0;
    end else begin : g_next
      assign v_in     = dv_q[s-1];
      assign neg_in   = dneg_q[s-1];
      assign raw_in_s = draw_q[s-1];
      assign lvl_in   = dlvl_q[s-1];
      assign rem_in   = drem_q[s-1];
      assign den_in   = dden_q[s-1];
      assign quo_in   = dquo_q[s-1];
    end

    assign st_a = wws_pkg::div_step(rem_in, den_in, wws_pkg::QUO_W - 1 - BS * s);
    assign st_b = wws_pkg::div_step(st_a.rem, den_in, wws_pkg::QUO_W - 2 - BS * s);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[s] <= 1'b0;
      end else if (adv) begin
        dv_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dneg_q[s] <= neg_in;
        draw_q[s] <= raw_in_s;
        dlvl_q[s] <= lvl_in;
        drem_q[s] <= st_b.rem;
        dden_q[s] <= den_in;
        dquo_q[s] <= quo_in | (wws_pkg::QUO_W'({st_a.bit_set, st_b.bit_set})
                               << (wws_pkg::QUO_W - BS - BS * s));
      end
    end
  end

  // final sign, zero-denominator and pass-through selection
  logic [CW-1:0] mag_res, res_d;
  assign mag_res = (dden_q[NS-1] == '0) ? '0 : CW'(dquo_q[NS-1]);
  assign res_d   = (dlvl_q[NS-1] == '0) ? draw_q[NS-1] :
                   (dneg_q[NS-1] ? (CW'(0) - mag_res) : mag_res);

  logic [CW-1:0] shrunk_q;
  logic [LW-1:0] level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      shrunk_q <= res_d;
      level_q  <= dlvl_q[NS-1];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign shrunk_value_o = shrunk_q;
  assign band_level_o   = level_q;

endmodule
